/* src/slfb_pkg.sv */
`timescale 1ns / 1ps

package slfb_pkg;

    localparam logic [2:0] CMD_FRAME = 3'd0;
    localparam logic [2:0] CMD_RAW   = 3'd1;
    localparam logic [2:0] CMD_DIGIT = 3'd2;
    localparam logic [2:0] CMD_SHOW3 = 3'd3;
    localparam logic [2:0] CMD_SHOW5 = 3'd4;
    localparam logic [2:0] CMD_CLEAR = 3'd5;

    localparam logic [4:0] CMD_LEN   = 5'd12;
    localparam logic [4:0] WR_LEN    = 5'd17;
    localparam logic [3:0] PFX_CMD   = 4'b1000;
    localparam logic [2:0] PFX_WR    = 3'b101;

    // x / 10 == (x * 0xCCCD) >> 19 for any 16-bit x
    localparam logic [16:0] RECIP10     = 17'd52429;
    localparam int          RECIP_SHIFT = 19;

    localparam logic [3:0] DIGIT_BLANK = 4'hF;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] value;
        logic        dot;
        logic [4:0]  place_one;
        logic [4:0]  place_two;
        logic [4:0]  place_three;
        logic [4:0]  place_four;
        logic [4:0]  place_five;
    } t_in_item;

    typedef struct packed {
        logic [16:0] frame_bits;
        logic [4:0]  frame_length;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic mul;
        logic sub;
        logic emit;
    } t_ctl_cmd;

    typedef struct packed {
        logic div_last;
        logic emit_last;
        logic out_free;
    } t_dp_stat;

    function automatic logic [7:0] seg_pattern(input logic [3:0] d);
        logic [7:0] p;
        case (d)
            4'd0: p = 8'h7D;
            4'd1: p = 8'h60;
            4'd2: p = 8'h3E;
            4'd3: p = 8'h7A;
            4'd4: p = 8'h63;
            4'd5: p = 8'h5B;
            4'd6: p = 8'h5F;
            4'd7: p = 8'h70;
            4'd8: p = 8'h7F;
            4'd9: p = 8'h7B;
            default: p = 8'h00;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] rev8(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = b[7 - i];
        end
        return r;
    endfunction

endpackage

/* src/slfb_ctrl.sv */
`timescale 1ns / 1ps

module slfb_ctrl
    import slfb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [2:0] i_command,
    output logic       o_in_ready,
    input  t_dp_stat   i_stat,
    output t_ctl_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_SUB  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_command inside {CMD_SHOW3, CMD_SHOW5}) begin
                        n_state = S_MUL;
                    end else if (i_command inside {CMD_FRAME, CMD_RAW, CMD_DIGIT, CMD_CLEAR}) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUB;
            end
            S_SUB: begin
                o_cmd.sub = 1'b1;
                n_state   = i_stat.div_last ? S_EMIT : S_MUL;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* src/slfb_datapath.sv */
`timescale 1ns / 1ps

module slfb_datapath
    import slfb_pkg::*;
#(
    parameter int CLEAR_PLACES = 17
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in,
    input  t_ctl_cmd  i_cmd,
    output t_dp_stat  o_stat,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out_item o_out
);

    localparam logic [4:0] CLEAR_LAST = 5'(CLEAR_PLACES - 1);

    logic [2:0]  r_cmd;
    logic [15:0] r_value;
    logic        r_dot;
    logic [4:0]  r_pl [5];
    logic [15:0] r_x;
    logic [15:0] r_q;
    logic [3:0]  r_digit [5];
    logic [1:0]  r_step;
    logic [4:0]  r_idx;
    logic [4:0]  r_last_idx;
    logic        r_out_valid;
    t_out_item   r_out;

    logic [32:0] w_prod;
    logic [15:0] w_rem;
    logic [2:0]  w_slot;
    logic [4:0]  w_place;
    logic [3:0]  w_digit;
    logic [7:0]  w_data;
    logic        w_is_last;
    logic        w_dot;
    logic [5:0]  w_addr;
    t_out_item   w_frame;

    assign w_prod = 33'(r_x) * 33'(RECIP10);
    assign w_rem  = 16'(r_x - {r_q[12:0], 3'b000} - {r_q[14:0], 1'b0});
    assign w_slot = r_last_idx[2:0] - {1'b0, r_step};

    assign o_stat.div_last  = (r_cmd == CMD_SHOW3) ? (r_step == 2'd1) : (r_step == 2'd3);
    assign o_stat.emit_last = (r_idx == r_last_idx);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd    <= i_in.command;
            r_value  <= i_in.value;
            r_dot    <= i_in.dot;
            r_pl[0]  <= i_in.place_one;
            r_pl[1]  <= i_in.place_two;
            r_pl[2]  <= i_in.place_three;
            r_pl[3]  <= i_in.place_four;
            r_pl[4]  <= i_in.place_five;
            r_x      <= i_in.value;
            r_step   <= 2'd0;
            r_idx    <= 5'd0;
            r_digit[0] <= (i_in.value > 16'd9) ? DIGIT_BLANK : i_in.value[3:0];
            case (i_in.command)
                CMD_SHOW3: r_last_idx <= 5'd2;
                CMD_SHOW5: r_last_idx <= 5'd4;
                CMD_CLEAR: r_last_idx <= CLEAR_LAST;
                default:   r_last_idx <= 5'd0;
            endcase
        end
        if (i_cmd.mul) begin
            r_q <= 16'(w_prod[32:RECIP_SHIFT]);
        end
        if (i_cmd.sub) begin
            r_x    <= r_q;
            r_step <= r_step + 2'd1;
            if (w_slot < 3'd5) begin
                r_digit[w_slot] <= w_rem[3:0];
            end
            if (o_stat.div_last) begin
                r_digit[0] <= (r_q > 16'd9) ? DIGIT_BLANK : r_q[3:0];
            end
        end
        if (i_cmd.emit) begin
            r_idx <= r_idx + 5'd1;
            r_out <= w_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        case (r_idx[2:0])
            3'd1:    w_place = r_pl[1];
            3'd2:    w_place = r_pl[2];
            3'd3:    w_place = r_pl[3];
            3'd4:    w_place = r_pl[4];
            default: w_place = r_pl[0];
        endcase
        w_digit   = (r_idx < 5'd5) ? r_digit[r_idx[2:0]] : DIGIT_BLANK;
        w_is_last = (r_idx == r_last_idx);
        w_dot     = w_is_last && ((r_cmd == CMD_DIGIT) ? r_dot : 1'b1);
        w_data    = seg_pattern(w_digit) | {w_dot, 7'b0};
        case (r_cmd)
            CMD_RAW: begin
                w_data = r_value[7:0];
            end
            CMD_CLEAR: begin
                w_place = r_idx;
                w_data  = 8'h00;
            end
            default: begin
            end
        endcase
        w_addr = {w_place, 1'b0} + 6'd63;
        w_frame.frame_bits   = {PFX_WR, w_addr, rev8(w_data)};
        w_frame.frame_length = WR_LEN;
        w_frame.last         = w_is_last;
        if (r_cmd == CMD_FRAME) begin
            w_frame.frame_bits   = {5'b00000, PFX_CMD, r_value[7:0]};
            w_frame.frame_length = CMD_LEN;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* src/segment_lcd_serial_frame_builder.sv */
`timescale 1ns / 1ps

// Channel | Direction | Handshake                    | Payload
// in      | input     | i_in_valid / o_in_ready      | i_in  (t_in_item)
// out     | output    | o_out_valid / i_out_ready    | o_out (t_out_item)
//
// A request is taken while idle, then one frame per cycle goes into the output register
// unless the output stalls. Three- and five-digit displays first split the value by two
// or four divides by ten, each a reciprocal multiply, then a remainder. Clear gives
// CLEAR_PLACES frames. Output stalls hold the frame sequencer; reset empties the output
// register.

module segment_lcd_serial_frame_builder
    import slfb_pkg::*;
#(
    parameter int CLEAR_PLACES = 17
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    t_ctl_cmd w_cmd;
    t_dp_stat w_stat;

    slfb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_in.command),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    slfb_datapath #(
        .CLEAR_PLACES (CLEAR_PLACES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule
